/* hdl/hte_pkg.sv */
// Shared types, constants and string helpers for the HTML text escaper.
package hte_pkg;

  localparam int unsigned HOLD_DEPTH = 32;
  localparam int unsigned HOLD_AW    = $clog2(HOLD_DEPTH);
  localparam int unsigned HOLD_CW    = $clog2(HOLD_DEPTH + 1);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_T    = 8'h74;

  typedef logic [HOLD_CW-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_t;

  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_AMP   = 5'b00010,
    MODE_ALPHA = 5'b00100,
    MODE_HASH  = 5'b01000,
    MODE_DIGIT = 5'b10000
  } scan_mode_e;

  typedef enum logic [2:0] {
    STR_AMP,
    STR_AND,
    STR_SEMI,
    STR_LT,
    STR_GT,
    STR_BYTE
  } str_e;

  // Output work for one transaction: leading flush, plain output, closing flush.
  typedef struct packed {
    logic       f1_on;
    logic       f1_acc;
    cnt_t       n1;
    logic       pl_on;
    str_e       pl_kind;
    logic [7:0] pl_byte;
    logic       f2_on;
    cnt_t       n2;
    logic       last;
  } job_t;

  function automatic logic [2:0] str_len(input str_e kind);
    logic [2:0] len;
    case (kind)
      STR_AMP: len = 3'd5;
      STR_LT:  len = 3'd4;
      STR_GT:  len = 3'd4;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] str_char(input str_e kind, input logic [2:0] pos,
                                          input logic [7:0] b);
    logic [7:0] c;
    c = CH_AMP;
    case (kind)
      STR_AMP: begin
        case (pos)
          3'd1:    c = CH_A;
          3'd2:    c = CH_M;
          3'd3:    c = CH_P;
          3'd4:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      STR_SEMI: c = CH_SEMI;
      STR_LT: begin
        case (pos)
          3'd1:    c = CH_L;
          3'd2:    c = CH_T;
          3'd3:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      STR_GT: begin
        case (pos)
          3'd1:    c = CH_G;
          3'd2:    c = CH_T;
          3'd3:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      STR_BYTE: c = b;
      default:  c = CH_AMP;
    endcase
    return c;
  endfunction

endpackage

/* hdl/hte_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module hte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/hte_scan.sv */
// Classifies one input byte against the scan mode and plans its output work.
module hte_scan (
  input  hte_pkg::scan_mode_e             mode_i,
  input  hte_pkg::cnt_t                   cnt_i,
  input  hte_pkg::in_t                    in_i,
  output hte_pkg::job_t                   job_o,
  output hte_pkg::scan_mode_e             mode_o,
  output hte_pkg::cnt_t                   cnt_o,
  output logic                            wr_en_o,
  output logic [hte_pkg::HOLD_AW-1:0]     wr_addr_o
);

  logic [7:0]          c;
  logic                alpha;
  logic                digit;
  logic                ext;
  logic                acc;
  logic                fail;
  logic                plain;
  logic                room;
  logic                handle_plain;
  hte_pkg::scan_mode_e ext_mode;
  hte_pkg::scan_mode_e mode_n;
  hte_pkg::cnt_t       cnt_n;

  assign c     = in_i.in_byte;
  assign alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign digit = (c >= 8'h30 && c <= 8'h39);
  assign room  = cnt_i < hte_pkg::cnt_t'(hte_pkg::HOLD_DEPTH);

  always_comb begin
    ext      = 1'b0;
    acc      = 1'b0;
    fail     = 1'b0;
    plain    = 1'b0;
    ext_mode = hte_pkg::MODE_PLAIN;
    unique case (mode_i)
      hte_pkg::MODE_AMP: begin
        if (alpha) begin
          ext      = 1'b1;
          ext_mode = hte_pkg::MODE_ALPHA;
        end else if (c == hte_pkg::CH_HASH) begin
          ext      = 1'b1;
          ext_mode = hte_pkg::MODE_HASH;
        end else begin
          fail = 1'b1;
        end
      end
      hte_pkg::MODE_ALPHA: begin
        if (alpha) begin
          ext      = 1'b1;
          ext_mode = hte_pkg::MODE_ALPHA;
        end else if (c == hte_pkg::CH_SEMI) begin
          acc = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      hte_pkg::MODE_HASH: begin
        if (digit) begin
          ext      = 1'b1;
          ext_mode = hte_pkg::MODE_DIGIT;
        end else begin
          fail = 1'b1;
        end
      end
      hte_pkg::MODE_DIGIT: begin
        if (digit) begin
          ext      = 1'b1;
          ext_mode = hte_pkg::MODE_DIGIT;
        end else if (c == hte_pkg::CH_SEMI) begin
          acc = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase
  end

  // A full run that would grow fails like any other broken reference.
  assign wr_en_o      = ext && room;
  assign wr_addr_o    = cnt_i[hte_pkg::HOLD_AW-1:0];
  assign handle_plain = plain || fail || (ext && !room);

  always_comb begin
    job_o         = '0;
    job_o.pl_kind = hte_pkg::STR_BYTE;
    job_o.pl_byte = c;
    job_o.last    = in_i.text_last;
    job_o.f1_on   = fail || acc || (ext && !room);
    job_o.f1_acc  = acc;
    job_o.n1      = cnt_i;
    mode_n        = mode_i;
    cnt_n         = cnt_i;
    if (wr_en_o) begin
      mode_n = ext_mode;
      cnt_n  = cnt_i + hte_pkg::cnt_t'(1);
    end
    if (acc) begin
      mode_n = hte_pkg::MODE_PLAIN;
      cnt_n  = '0;
    end
    if (handle_plain) begin
      mode_n = hte_pkg::MODE_PLAIN;
      cnt_n  = '0;
      if (c == hte_pkg::CH_LT) begin
        job_o.pl_on   = 1'b1;
        job_o.pl_kind = hte_pkg::STR_LT;
      end else if (c == hte_pkg::CH_GT) begin
        job_o.pl_on   = 1'b1;
        job_o.pl_kind = hte_pkg::STR_GT;
      end else if (c == hte_pkg::CH_AMP) begin
        mode_n = hte_pkg::MODE_AMP;
        cnt_n  = hte_pkg::cnt_t'(1);
      end else begin
        job_o.pl_on = 1'b1;
      end
    end
    job_o.n2 = cnt_n;
    mode_o   = mode_n;
    cnt_o    = cnt_n;
    if (in_i.text_last && mode_n != hte_pkg::MODE_PLAIN) begin
      job_o.f2_on = 1'b1;
      mode_o      = hte_pkg::MODE_PLAIN;
      cnt_o       = '0;
    end
  end

endmodule

/* hdl/html_text_escaper_top.sv */
// Top level of the HTML text escaper: sequencer, held-run RAM and output register.
// The escaper gives one output byte per clock while the output side takes it. The
// next input transaction is taken in the cycle of the final result, so plain bytes
// stream at one per clock while the output is not stalled. Escapes give 4 or 5
// bytes, and a held run of n bytes is replayed from the held-byte RAM one byte per
// cycle at its read port while the output takes it, plus the "&amp;" or "&" and ";"
// around it.
module html_text_escaper_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hte_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hte_pkg::out_t out_data_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_HEAD1 = 7'b0000010,
    ST_HELD1 = 7'b0000100,
    ST_TAIL1 = 7'b0001000,
    ST_PLAIN = 7'b0010000,
    ST_HEAD2 = 7'b0100000,
    ST_HELD2 = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  state_e                        seg_next;
  state_e                        start_state;
  state_e                        nx_plain, nx_tail1, nx_held1, nx_head1, nx_head2;
  hte_pkg::scan_mode_e           mode_q, mode_d, scan_mode;
  hte_pkg::cnt_t                 cnt_q, cnt_d, scan_cnt;
  hte_pkg::job_t                 job_q, job_d, scan_job;
  hte_pkg::out_t                 out_q, out_d;
  logic                          out_valid_q, out_valid_d;
  logic [2:0]                    pos_q, pos_d;
  logic [hte_pkg::HOLD_AW-1:0]   idx_q, idx_d;
  logic [hte_pkg::HOLD_AW-1:0]   wr_addr;
  logic                          scan_wr;
  logic [7:0]                    rd_data;
  logic [7:0]                    emit_byte;
  hte_pkg::str_e                 kind;
  hte_pkg::cnt_t                 held_n;
  logic                          is_held;
  logic                          slot_free;
  logic                          emit;
  logic                          seg_done;
  logic                          run_end;
  logic                          accept;

  hte_scan u_scan (
    .mode_i    (mode_q),
    .cnt_i     (cnt_q),
    .in_i      (in_data_i),
    .job_o     (scan_job),
    .mode_o    (scan_mode),
    .cnt_o     (scan_cnt),
    .wr_en_o   (scan_wr),
    .wr_addr_o (wr_addr)
  );

  hte_ram #(
    .WIDTH (8),
    .DEPTH (hte_pkg::HOLD_DEPTH)
  ) u_held (
    .clk_i   (clk_i),
    .we_i    (accept && scan_wr),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.in_byte),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  assign nx_plain = job_q.f2_on ? ST_HEAD2 : ST_IDLE;
  assign nx_tail1 = job_q.pl_on ? ST_PLAIN : nx_plain;
  assign nx_held1 = job_q.f1_acc ? ST_TAIL1 : nx_tail1;
  assign nx_head1 = (job_q.n1 > hte_pkg::cnt_t'(1)) ? ST_HELD1 : nx_held1;
  assign nx_head2 = (job_q.n2 > hte_pkg::cnt_t'(1)) ? ST_HELD2 : ST_IDLE;

  assign start_state = scan_job.f1_on ? ST_HEAD1 :
                       scan_job.pl_on ? ST_PLAIN :
                       scan_job.f2_on ? ST_HEAD2 : ST_IDLE;

  always_comb begin
    kind     = hte_pkg::STR_AMP;
    seg_next = ST_IDLE;
    unique case (state_q)
      ST_HEAD1: begin
        kind     = job_q.f1_acc ? hte_pkg::STR_AND : hte_pkg::STR_AMP;
        seg_next = nx_head1;
      end
      ST_HELD1: seg_next = nx_held1;
      ST_TAIL1: begin
        kind     = hte_pkg::STR_SEMI;
        seg_next = nx_tail1;
      end
      ST_PLAIN: begin
        kind     = job_q.pl_kind;
        seg_next = nx_plain;
      end
      ST_HEAD2: seg_next = nx_head2;
      default:  seg_next = ST_IDLE;
    endcase
  end

  // Held entry 0 stands for the '&', which is never written; the head string produces it instead.
  assign is_held   = (state_q == ST_HELD1) || (state_q == ST_HELD2);
  assign held_n    = (state_q == ST_HELD2) ? job_q.n2 : job_q.n1;
  assign seg_done  = is_held ? (hte_pkg::cnt_t'(idx_q) + hte_pkg::cnt_t'(1) == held_n)
                             : (pos_q == hte_pkg::str_len(kind) - 3'd1);
  assign emit_byte = is_held ? rd_data : hte_pkg::str_char(kind, pos_q, job_q.pl_byte);
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (state_q != ST_IDLE) && slot_free;
  assign run_end   = seg_done && (seg_next == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE) || (emit && run_end);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    job_d       = job_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    // Outside a replay the read port keeps refetching entry 1, so a byte
    // written at acceptance is seen before any replay starts.
    if (!is_held) begin
      idx_d = hte_pkg::HOLD_AW'(1);
    end
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.out_byte   = emit_byte;
      out_d.run_last   = run_end;
      out_d.text_end   = run_end && job_q.last;
      if (seg_done) begin
        state_d = seg_next;
        pos_d   = '0;
      end else if (is_held) begin
        idx_d = idx_q + hte_pkg::HOLD_AW'(1);
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
    if (accept) begin
      job_d   = scan_job;
      mode_d  = scan_mode;
      cnt_d   = scan_cnt;
      state_d = start_state;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= hte_pkg::MODE_PLAIN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      idx_q       <= hte_pkg::HOLD_AW'(1);
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hte_pkg::cnt_t'(hte_pkg::HOLD_DEPTH))
    else $error("held count beyond hold depth");

  a_mode_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == hte_pkg::MODE_PLAIN) == (cnt_q == '0))
    else $error("scan mode and held count disagree");

  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_held |-> (idx_q != '0) && (hte_pkg::cnt_t'(idx_q) < held_n))
    else $error("replay index outside held run");

  a_replay_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_held && !slot_free) |=> (idx_q == $past(idx_q)) && $stable(state_q))
    else $error("replay advanced while output stalled");

endmodule
